// ===== hdl/quaternion_vector_rotation_defines.svh =====
// Assertion macros used by the checker of the quaternion rotation block.
`ifndef QUATERNION_VECTOR_ROTATION_DEFINES_SVH
`define QUATERNION_VECTOR_ROTATION_DEFINES_SVH

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define QVR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Whenever the antecedent holds, the consequent must hold in the next cycle.
`define QVR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/qvr_pkg.sv =====
package qvr_pkg;

  // Quaternion parts are always 16-bit signed.
  localparam int unsigned QUAT_W = 16;
  // Exact pairwise quaternion product.
  localparam int unsigned PROD_W = 2 * QUAT_W;
  // Rotation matrix entry: a signed sum of four squares, or twice a sum or difference of two products.
  localparam int unsigned COEF_W = PROD_W + 2;

  typedef logic signed [QUAT_W-1:0] qvr_quat_t;
  typedef logic signed [PROD_W-1:0] qvr_prod_t;
  typedef logic signed [COEF_W-1:0] qvr_coef_t;

  // One row of the rotation matrix.
  typedef struct packed {
    qvr_coef_t c0;
    qvr_coef_t c1;
    qvr_coef_t c2;
  } qvr_row_coef_t;

  // Load enables of the pipeline stages, from the input side onwards.
  typedef struct packed {
    logic prod;
    logic coef;
    logic mul;
    logic sum;
    logic sat;
  } qvr_pipe_en_t;

endpackage

// ===== hdl/qvr_coef.sv =====
module qvr_coef (
  input  logic                  clk_i,
  input  qvr_pkg::qvr_pipe_en_t en_i,
  input  qvr_pkg::qvr_quat_t    quat_w_i,
  input  qvr_pkg::qvr_quat_t    quat_x_i,
  input  qvr_pkg::qvr_quat_t    quat_y_i,
  input  qvr_pkg::qvr_quat_t    quat_z_i,
  output qvr_pkg::qvr_row_coef_t row_x_o,
  output qvr_pkg::qvr_row_coef_t row_y_o,
  output qvr_pkg::qvr_row_coef_t row_z_o
);
  import qvr_pkg::*;

  qvr_prod_t ww_q, xx_q, yy_q, zz_q, wx_q, wy_q, wz_q, xy_q, xz_q, yz_q;
  qvr_row_coef_t row_x_d, row_y_d, row_z_d;
  qvr_row_coef_t row_x_q, row_y_q, row_z_q;

  // First stage: the ten exact products.
  always_ff @(posedge clk_i) begin
    if (en_i.prod) begin
      ww_q <= quat_w_i * quat_w_i;
      xx_q <= quat_x_i * quat_x_i;
      yy_q <= quat_y_i * quat_y_i;
      zz_q <= quat_z_i * quat_z_i;
      wx_q <= quat_w_i * quat_x_i;
      wy_q <= quat_w_i * quat_y_i;
      wz_q <= quat_w_i * quat_z_i;
      xy_q <= quat_x_i * quat_y_i;
      xz_q <= quat_x_i * quat_z_i;
      yz_q <= quat_y_i * quat_z_i;
    end
  end

  // Second stage: the nine matrix entries, widened so that nothing overflows.
  always_comb begin
    row_x_d.c0 = COEF_W'(ww_q) + COEF_W'(xx_q) - COEF_W'(yy_q) - COEF_W'(zz_q);
    row_x_d.c1 = (COEF_W'(xy_q) - COEF_W'(wz_q)) <<< 1;
    row_x_d.c2 = (COEF_W'(wy_q) + COEF_W'(xz_q)) <<< 1;
    row_y_d.c0 = (COEF_W'(xy_q) + COEF_W'(wz_q)) <<< 1;
    row_y_d.c1 = COEF_W'(ww_q) - COEF_W'(xx_q) + COEF_W'(yy_q) - COEF_W'(zz_q);
    row_y_d.c2 = (COEF_W'(yz_q) - COEF_W'(wx_q)) <<< 1;
    row_z_d.c0 = (COEF_W'(xz_q) - COEF_W'(wy_q)) <<< 1;
    row_z_d.c1 = (COEF_W'(yz_q) + COEF_W'(wx_q)) <<< 1;
    row_z_d.c2 = COEF_W'(ww_q) - COEF_W'(xx_q) - COEF_W'(yy_q) + COEF_W'(zz_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.coef) begin
      row_x_q <= row_x_d;
      row_y_q <= row_y_d;
      row_z_q <= row_z_d;
    end
  end

  assign row_x_o = row_x_q;
  assign row_y_o = row_y_q;
  assign row_z_o = row_z_q;

endmodule

// ===== hdl/qvr_row.sv =====
module qvr_row #(
  parameter int unsigned VEC_BITS       = 16,
  parameter int unsigned QUAT_FRAC_BITS = 14
) (
  input  logic                   clk_i,
  input  qvr_pkg::qvr_pipe_en_t  en_i,
  input  qvr_pkg::qvr_row_coef_t coef_i,
  input  logic signed [VEC_BITS-1:0] vec0_i,
  input  logic signed [VEC_BITS-1:0] vec1_i,
  input  logic signed [VEC_BITS-1:0] vec2_i,
  output logic signed [VEC_BITS-1:0] rot_o,
  output logic                   clip_o
);
  import qvr_pkg::*;

  localparam int unsigned MUL_W   = COEF_W + VEC_BITS;
  localparam int unsigned SHIFT   = 2 * QUAT_FRAC_BITS;
  localparam int unsigned ACC_W   = MUL_W + 2;
  localparam int unsigned SUM_W   = (ACC_W > SHIFT + 2) ? ACC_W : SHIFT + 2;
  localparam int unsigned HI_W    = SUM_W - VEC_BITS + 1;
  localparam logic signed [SUM_W-1:0] RND = {{(SUM_W-1){1'b0}}, 1'b1} << (SHIFT - 1);
  localparam logic signed [VEC_BITS-1:0] VMAX = {1'b0, {(VEC_BITS-1){1'b1}}};
  localparam logic signed [VEC_BITS-1:0] VMIN = {1'b1, {(VEC_BITS-1){1'b0}}};

  logic signed [MUL_W-1:0] prod0_q, prod1_q, prod2_q;
  logic signed [SUM_W-1:0] sum_d, sum_q, shr;
  logic        [HI_W-1:0]  hi;
  logic                    pos_ovf, neg_ovf;
  logic signed [VEC_BITS-1:0] rot_d, rot_q;
  logic                    clip_d, clip_q;

  always_ff @(posedge clk_i) begin
    if (en_i.mul) begin
      prod0_q <= $signed(coef_i.c0) * vec0_i;
      prod1_q <= $signed(coef_i.c1) * vec1_i;
      prod2_q <= $signed(coef_i.c2) * vec2_i;
    end
  end

  // Exact dot product plus the half-unit rounding constant.
  assign sum_d = SUM_W'(prod0_q) + SUM_W'(prod1_q) + SUM_W'(prod2_q) + RND;

  always_ff @(posedge clk_i) begin
    if (en_i.sum) begin
      sum_q <= sum_d;
    end
  end

  // The arithmetic shift floors, so with the constant above this rounds half up.
  assign shr     = sum_q >>> SHIFT;
  assign hi      = shr[SUM_W-1:VEC_BITS-1];
  assign pos_ovf = !shr[SUM_W-1] && (|hi);
  assign neg_ovf = shr[SUM_W-1] && !(&hi);

  always_comb begin
    priority if (pos_ovf) begin
      rot_d = VMAX;
    end else if (neg_ovf) begin
      rot_d = VMIN;
    end else begin
      rot_d = shr[VEC_BITS-1:0];
    end
    clip_d = pos_ovf || neg_ovf;
  end

  always_ff @(posedge clk_i) begin
    if (en_i.sat) begin
      rot_q  <= rot_d;
      clip_q <= clip_d;
    end
  end

  assign rot_o  = rot_q;
  assign clip_o = clip_q;

endmodule

// ===== hdl/quaternion_vector_rotation.sv =====
// Rotates a 3D vector by a quaternion, p' = q p q*, in exact integer
// arithmetic. Each input transaction carries the quaternion in signed Q1.14
// (16384 stands for 1.0) and the vector in signed VEC_BITS-bit units; each
// output transaction carries the rotated vector, rounded half up from
// 2*QUAT_FRAC_BITS fraction bits and saturated, plus a flag that is set when
// any component was saturated. The block takes one transaction in every
// clock cycle while the consumer keeps taking results; each result passes
// through five register stages (quaternion products, matrix entries, the
// nine coefficient-by-vector multipliers, the dot-product sum, and the
// round-and-saturate output register). Each stage advances independently,
// so a stalled output fills bubbles before back-pressure reaches the input.
module quaternion_vector_rotation #(
  parameter int unsigned VEC_BITS       = 16,
  parameter int unsigned QUAT_FRAC_BITS = 14
) (
  input  logic clk_i,
  input  logic rst_ni,
  // Input transaction.
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // From bit 0 up: quat_w, quat_x, quat_y, quat_z (16 bits each), then
  // vec_x, vec_y, vec_z (VEC_BITS each), zero-padded to whole bytes.
  input  logic [((4*qvr_pkg::QUAT_W+3*VEC_BITS+7)/8)*8-1:0] s_axis_tdata,
  // Output transaction.
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // From bit 0 up: rot_x, rot_y, rot_z (VEC_BITS each), zero-padded to bytes.
  output logic [((3*VEC_BITS+7)/8)*8-1:0] m_axis_tdata,
  // Bit 0: clipped.
  output logic m_axis_tuser
);
  import qvr_pkg::*;

  localparam int unsigned STAGES = 5;
  localparam int unsigned VEC_LO = 4 * QUAT_W;
  localparam int unsigned OUT_W  = ((3 * VEC_BITS + 7) / 8) * 8;

  logic [STAGES-1:0] valid_d, valid_q;
  logic [STAGES-1:0] en;
  qvr_pipe_en_t      pipe_en;

  logic signed [VEC_BITS-1:0] vec_s1_q [3];
  logic signed [VEC_BITS-1:0] vec_s2_q [3];

  qvr_quat_t     quat_w, quat_x, quat_y, quat_z;
  qvr_row_coef_t row_x, row_y, row_z;
  logic signed [VEC_BITS-1:0] rot_x, rot_y, rot_z;
  logic          clip_x, clip_y, clip_z;

  // A stage may load when it is empty or when the stage after it loads in
  // the same cycle; the last stage frees up when the consumer takes its data.
  always_comb begin
    en[STAGES-1] = !valid_q[STAGES-1] || m_axis_tready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  always_comb begin
    for (int k = 0; k < STAGES; k++) begin
      if (!en[k]) begin
        valid_d[k] = valid_q[k];
      end else if (k == 0) begin
        valid_d[k] = s_axis_tvalid;
      end else begin
        valid_d[k] = valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign pipe_en.prod = en[0];
  assign pipe_en.coef = en[1];
  assign pipe_en.mul  = en[2];
  assign pipe_en.sum  = en[3];
  assign pipe_en.sat  = en[4];

  assign s_axis_tready = en[0];

  // Unpack the input transaction.
  assign quat_w = s_axis_tdata[QUAT_W-1:0];
  assign quat_x = s_axis_tdata[2*QUAT_W-1:QUAT_W];
  assign quat_y = s_axis_tdata[3*QUAT_W-1:2*QUAT_W];
  assign quat_z = s_axis_tdata[4*QUAT_W-1:3*QUAT_W];

  // The vector rides alongside the quaternion until the multipliers need it.
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      for (int i = 0; i < 3; i++) begin
        vec_s1_q[i] <= s_axis_tdata[VEC_LO + i*VEC_BITS +: VEC_BITS];
      end
    end
    if (en[1]) begin
      vec_s2_q <= vec_s1_q;
    end
  end

  qvr_coef u_coef (
    .clk_i    (clk_i),
    .en_i     (pipe_en),
    .quat_w_i (quat_w),
    .quat_x_i (quat_x),
    .quat_y_i (quat_y),
    .quat_z_i (quat_z),
    .row_x_o  (row_x),
    .row_y_o  (row_y),
    .row_z_o  (row_z)
  );

  qvr_row #(
    .VEC_BITS       (VEC_BITS),
    .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
  ) u_row_x (
    .clk_i  (clk_i),
    .en_i   (pipe_en),
    .coef_i (row_x),
    .vec0_i (vec_s2_q[0]),
    .vec1_i (vec_s2_q[1]),
    .vec2_i (vec_s2_q[2]),
    .rot_o  (rot_x),
    .clip_o (clip_x)
  );

  qvr_row #(
    .VEC_BITS       (VEC_BITS),
    .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
  ) u_row_y (
    .clk_i  (clk_i),
    .en_i   (pipe_en),
    .coef_i (row_y),
    .vec0_i (vec_s2_q[0]),
    .vec1_i (vec_s2_q[1]),
    .vec2_i (vec_s2_q[2]),
    .rot_o  (rot_y),
    .clip_o (clip_y)
  );

  qvr_row #(
    .VEC_BITS       (VEC_BITS),
    .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
  ) u_row_z (
    .clk_i  (clk_i),
    .en_i   (pipe_en),
    .coef_i (row_z),
    .vec0_i (vec_s2_q[0]),
    .vec1_i (vec_s2_q[1]),
    .vec2_i (vec_s2_q[2]),
    .rot_o  (rot_z),
    .clip_o (clip_z)
  );

  // The row outputs are the output register itself.
  assign m_axis_tvalid = valid_q[STAGES-1];
  assign m_axis_tdata  = OUT_W'({rot_z, rot_y, rot_x});
  assign m_axis_tuser  = clip_x || clip_y || clip_z;

endmodule

// ===== hdl/qvr_checker.sv =====
module qvr_checker #(
  parameter int unsigned VEC_BITS = 16
) (
  input logic clk_i,
  input logic rst_ni,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [((3*VEC_BITS+7)/8)*8-1:0] m_axis_tdata,
  input logic m_axis_tuser
);
`include "quaternion_vector_rotation_defines.svh"

  localparam logic [VEC_BITS-1:0] VMAX = {1'b0, {(VEC_BITS-1){1'b1}}};
  localparam logic [VEC_BITS-1:0] VMIN = {1'b1, {(VEC_BITS-1){1'b0}}};

  logic [VEC_BITS-1:0] rx, ry, rz;
  logic                at_limit;

  assign rx = m_axis_tdata[VEC_BITS-1:0];
  assign ry = m_axis_tdata[2*VEC_BITS-1:VEC_BITS];
  assign rz = m_axis_tdata[3*VEC_BITS-1:2*VEC_BITS];
  assign at_limit = (rx == VMAX) || (rx == VMIN) || (ry == VMAX) || (ry == VMIN)
                 || (rz == VMAX) || (rz == VMIN);

  `QVR_ASSERT_NEXT(a_valid_held, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "output valid dropped while stalled")
  `QVR_ASSERT_NEXT(a_data_held, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tuser), "output payload changed while stalled")
  `QVR_ASSERT_SAME(a_clip_at_limit, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser, at_limit, "clipped set but no component at a limit")
  `QVR_ASSERT_SAME(a_ready_when_empty, clk_i, rst_ni, !m_axis_tvalid, s_axis_tready, "input not ready although output stage is empty")

endmodule

bind quaternion_vector_rotation qvr_checker #(.VEC_BITS(VEC_BITS)) u_qvr_checker (.*);

// ===== dv/quaternion_vector_rotation_tb.sv =====
`timescale 1ns / 100ps

// Testbench for the quaternion vector rotation block. Each input transaction
// carries a quaternion and a vector; the expected rotated vector and clip
// flag are worked out here in exact 64-bit integer arithmetic and compared,
// field by field and in order, with every output transaction. The run goes
// through a short list of hand-picked cases, random unit rotations, random
// raw bit patterns, a long output stall and a final stretch at full rate.
module quaternion_vector_rotation_tb;
  import qvr_pkg::*;

  localparam int unsigned VEC_BITS       = 16;
  localparam int unsigned QUAT_FRAC_BITS = 14;
  localparam int unsigned IN_BITS        = ((4*QUAT_W+3*VEC_BITS+7)/8)*8;
  localparam int unsigned OUT_BITS       = ((3*VEC_BITS+7)/8)*8;

  // The output stall used to fill the pipeline and back-pressure the input.
  localparam int HOLD_CYCLES  = 200;
  // The block has five register stages; this leaves ample margin after the
  // last result before the verdict.
  localparam int DRAIN_CYCLES = 20;
  // Enough for roughly 2000 transactions with all their gaps and stalls.
  localparam int LIMIT_NS     = 2_000_000;

  localparam longint VEC_MAX = (longint'(1) <<< (VEC_BITS-1)) - 1;
  localparam longint VEC_MIN = -VEC_MAX - 1;

  typedef logic signed [VEC_BITS-1:0] vec_t;

  typedef struct packed {
    qvr_quat_t qw;
    qvr_quat_t qx;
    qvr_quat_t qy;
    qvr_quat_t qz;
    vec_t      vx;
    vec_t      vy;
    vec_t      vz;
  } rotation_in_t;

  typedef struct packed {
    vec_t rx;
    vec_t ry;
    vec_t rz;
    logic clipped;
  } rotation_out_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  // From bit 0 up: quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z.
  logic [IN_BITS-1:0]  s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  // From bit 0 up: rot_x, rot_y, rot_z.
  logic [OUT_BITS-1:0] m_axis_tdata;
  // Bit 0: clipped.
  logic                m_axis_tuser;

  // Results still owed by the block, oldest first.
  rotation_out_t rotations_due[$];
  int fail_count   = 0;
  // Random gaps on the sender and stalls on the receiver while this is set.
  bit idling_on    = 1'b1;
  // Asks the receiver process for one long stall.
  bit hold_request = 1'b0;

  quaternion_vector_rotation #(
    .VEC_BITS      (VEC_BITS),
    .QUAT_FRAC_BITS(QUAT_FRAC_BITS)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Divides an exact sum by 2^(2*QUAT_FRAC_BITS), rounding half up. The
  // arithmetic shift of a signed value is a floor, so adding half first
  // gives round-half-up for negative sums as well.
  function automatic longint rounded_shift(input longint acc);
    return (acc + (longint'(1) <<< (2*QUAT_FRAC_BITS-1))) >>> (2*QUAT_FRAC_BITS);
  endfunction

  // Expected result for one input transaction: the rotation matrix is built
  // from the ten exact quaternion products, each row is dotted with the
  // vector exactly, then rounded and saturated. Worst-case magnitudes stay
  // near 2^49, well inside 64 bits.
  function automatic rotation_out_t predict_rotation(input rotation_in_t item);
    longint w, x, y, z;
    longint ww, xx, yy, zz, wx, wy, wz, xy, xz, yz;
    longint v [3];
    longint m [3][3];
    longint r;
    vec_t rot [3];
    int i;
    rotation_out_t res;
    w = longint'($signed(item.qw));
    x = longint'($signed(item.qx));
    y = longint'($signed(item.qy));
    z = longint'($signed(item.qz));
    v[0] = longint'($signed(item.vx));
    v[1] = longint'($signed(item.vy));
    v[2] = longint'($signed(item.vz));
    ww = w*w; xx = x*x; yy = y*y; zz = z*z;
    wx = w*x; wy = w*y; wz = w*z;
    xy = x*y; xz = x*z; yz = y*z;
    m[0][0] = ww + xx - yy - zz;
    m[0][1] = 2*(xy - wz);
    m[0][2] = 2*(wy + xz);
    m[1][0] = 2*(xy + wz);
    m[1][1] = ww - xx + yy - zz;
    m[1][2] = 2*(yz - wx);
    m[2][0] = 2*(xz - wy);
    m[2][1] = 2*(yz + wx);
    m[2][2] = ww - xx - yy + zz;
    res.clipped = 1'b0;
    for (i = 0; i < 3; i++) begin
      r = rounded_shift(m[i][0]*v[0] + m[i][1]*v[1] + m[i][2]*v[2]);
      if (r > VEC_MAX) begin
        r = VEC_MAX;
        res.clipped = 1'b1;
      end else if (r < VEC_MIN) begin
        r = VEC_MIN;
        res.clipped = 1'b1;
      end
      rot[i] = vec_t'(r);
    end
    res.rx = rot[0];
    res.ry = rot[1];
    res.rz = rot[2];
    return res;
  endfunction

  function automatic rotation_in_t make_rotation(input int qw, input int qx, input int qy,
                                                 input int qz, input int vx, input int vy,
                                                 input int vz);
    rotation_in_t item;
    item.qw = qvr_quat_t'(qw);
    item.qx = qvr_quat_t'(qx);
    item.qy = qvr_quat_t'(qy);
    item.qz = qvr_quat_t'(qz);
    item.vx = vec_t'(vx);
    item.vy = vec_t'(vy);
    item.vz = vec_t'(vz);
    return item;
  endfunction

  // Offers one input transaction, after an optional random gap, and records
  // its expected result once the block has accepted it. Inputs change on the
  // falling edge; acceptance is judged at the rising edge.
  task automatic send_rotation(input rotation_in_t item);
    int gap;
    if (idling_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 16);
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {item.vz, item.vy, item.vx, item.qz, item.qy, item.qx, item.qw};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    rotations_due.push_back(predict_rotation(item));
  endtask

  // Receiver: random stalls, or one long stall on request.
  // The stall length is counted here so that the sender carries on offering
  // transactions while the output is held.
  initial begin
    int stall_left;
    stall_left    = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else if (hold_request) begin
        m_axis_tready <= 1'b0;
        stall_left   = HOLD_CYCLES - 1;
        hold_request = 1'b0;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        stall_left = $urandom_range(1, 16) - 1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Each output transaction is matched against the oldest outstanding
  // expectation.
  always @(posedge clk_i) begin : result_check
    rotation_out_t got;
    rotation_out_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.rx      = m_axis_tdata[VEC_BITS-1:0];
      got.ry      = m_axis_tdata[2*VEC_BITS-1:VEC_BITS];
      got.rz      = m_axis_tdata[3*VEC_BITS-1:2*VEC_BITS];
      got.clipped = m_axis_tuser;
      if (rotations_due.size() == 0) begin
        $error("unexpected output transaction: rot_x %0d rot_y %0d rot_z %0d clipped %0b",
               got.rx, got.ry, got.rz, got.clipped);
        fail_count++;
      end else begin
        want = rotations_due.pop_front();
        if (got.rx !== want.rx) begin
          $error("rot_x: expected %0d, actual %0d", want.rx, got.rx);
          fail_count++;
        end
        if (got.ry !== want.ry) begin
          $error("rot_y: expected %0d, actual %0d", want.ry, got.ry);
          fail_count++;
        end
        if (got.rz !== want.rz) begin
          $error("rot_z: expected %0d, actual %0d", want.rz, got.rz);
          fail_count++;
        end
        if (got.clipped !== want.clipped) begin
          $error("clipped: expected %0b, actual %0b", want.clipped, got.clipped);
          fail_count++;
        end
      end
    end
  end

  // Hand-picked cases: identity and its negation, quarter turns about each
  // axis, half turns about x, the zero quaternion, non-unit and out-of-range
  // quaternions that force saturation, and exact halves for the rounding.
  task automatic test_directed_cases();
    send_rotation(make_rotation(16384, 0, 0, 0, 1000, -2000, 3000));
    send_rotation(make_rotation(16384, 0, 0, 0, 32767, -32768, 0));
    send_rotation(make_rotation(-16384, 0, 0, 0, -32768, 32767, -1));
    send_rotation(make_rotation(11585, 0, 0, 11585, 10000, 0, 0));
    send_rotation(make_rotation(11585, 11585, 0, 0, 0, 20000, -20000));
    send_rotation(make_rotation(11585, 0, 11585, 0, -12345, 777, 32767));
    send_rotation(make_rotation(0, 16384, 0, 0, 32767, 32767, 32767));
    // A half turn about x negates y and z, so the most negative value clips.
    send_rotation(make_rotation(0, 16384, 0, 0, -32768, -32768, -32768));
    send_rotation(make_rotation(0, 0, 0, 0, 32767, -32768, 12345));
    send_rotation(make_rotation(16384, 16384, 16384, 16384, 32767, 32767, 32767));
    send_rotation(make_rotation(-16384, -16384, -16384, -16384, -32768, 1, -32768));
    send_rotation(make_rotation(-32768, -32768, -32768, -32768, -32768, -32768, -32768));
    send_rotation(make_rotation(32767, 32767, -32768, 0, 1, -1, 1));
    send_rotation(make_rotation(32767, -32768, 32767, -32768, 32767, -32768, 32767));
    // A quaternion of one half scales by a quarter: these land on and near
    // exact halves of the output step.
    send_rotation(make_rotation(8192, 0, 0, 0, 1, -1, 3));
    send_rotation(make_rotation(8192, 0, 0, 0, 2, -2, -3));
    send_rotation(make_rotation(1, 0, 0, 0, 32767, -32768, 32767));
    send_rotation(make_rotation(9459, -9459, 9459, -9459, 0, 0, 0));
    send_rotation(make_rotation(9459, 9459, 9459, 9459, 30000, -30000, 30000));
  endtask

  // Rotations by random quaternions scaled to unit norm, the normal use of
  // the block; a quarter of the vectors are small.
  task automatic test_random_unit_rotations(input int count);
    real a, b, c, d, norm;
    int vx, vy, vz;
    int n;
    for (n = 0; n < count; n++) begin
      a = real'(int'($urandom_range(0, 32768)) - 16384);
      b = real'(int'($urandom_range(0, 32768)) - 16384);
      c = real'(int'($urandom_range(0, 32768)) - 16384);
      d = real'(int'($urandom_range(0, 32768)) - 16384);
      norm = $sqrt(a*a + b*b + c*c + d*d);
      if (norm < 1.0) begin
        a = 1.0; b = 0.0; c = 0.0; d = 0.0; norm = 1.0;
      end
      if ($urandom_range(0, 3) == 0) begin
        vx = int'($urandom_range(0, 511)) - 256;
        vy = int'($urandom_range(0, 511)) - 256;
        vz = int'($urandom_range(0, 511)) - 256;
      end else begin
        vx = int'($urandom_range(0, 65535)) - 32768;
        vy = int'($urandom_range(0, 65535)) - 32768;
        vz = int'($urandom_range(0, 65535)) - 32768;
      end
      send_rotation(make_rotation($rtoi(a / norm * 16384.0 + (a >= 0.0 ? 0.5 : -0.5)),
                                  $rtoi(b / norm * 16384.0 + (b >= 0.0 ? 0.5 : -0.5)),
                                  $rtoi(c / norm * 16384.0 + (c >= 0.0 ? 0.5 : -0.5)),
                                  $rtoi(d / norm * 16384.0 + (d >= 0.0 ? 0.5 : -0.5)),
                                  vx, vy, vz));
    end
  endtask

  // Non-unit quaternions: half take any 16-bit pattern, half stay within
  // +-1.0. Saturation is frequent here.
  task automatic test_random_raw_patterns(input int count);
    int n;
    for (n = 0; n < count; n++) begin
      if (n % 2 == 0) begin
        send_rotation(make_rotation(int'($urandom), int'($urandom), int'($urandom),
                                    int'($urandom), int'($urandom), int'($urandom),
                                    int'($urandom)));
      end else begin
        send_rotation(make_rotation(int'($urandom_range(0, 32768)) - 16384,
                                    int'($urandom_range(0, 32768)) - 16384,
                                    int'($urandom_range(0, 32768)) - 16384,
                                    int'($urandom_range(0, 32768)) - 16384,
                                    int'($urandom), int'($urandom), int'($urandom)));
      end
    end
  endtask

  // The output is held for a long stretch while the sender keeps offering
  // back to back, so the pipeline fills and the input must stall.
  task automatic test_output_backpressure(input int count);
    int n;
    idling_on    = 1'b0;
    hold_request = 1'b1;
    for (n = 0; n < count; n++) begin
      send_rotation(make_rotation(int'($urandom_range(0, 32768)) - 16384,
                                  int'($urandom_range(0, 32768)) - 16384,
                                  int'($urandom_range(0, 32768)) - 16384,
                                  int'($urandom_range(0, 32768)) - 16384,
                                  int'($urandom), int'($urandom), int'($urandom)));
    end
    idling_on = 1'b1;
  endtask

  // Full rate on both sides: one transaction every cycle.
  task automatic test_steady_stream(input int count);
    idling_on = 1'b0;
    test_random_unit_rotations(count);
  endtask

  initial begin
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    rst_ni        = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_cases();
    test_random_unit_rotations(1200);
    test_random_raw_patterns(400);
    test_output_backpressure(40);
    test_steady_stream(300);

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (rotations_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("PASS quaternion_vector_rotation");
    end else begin
      $display("FAIL quaternion_vector_rotation");
    end
    $finish;
  end

  // Watchdog against a block that stops delivering.
  initial begin
    #(LIMIT_NS);
    $display("FAIL quaternion_vector_rotation");
    $finish;
  end

endmodule
